/* src/spba_pkg.sv */
// ----------------------------------------------------------------------------
// spba_pkg
// Types, opcodes and fixed-point constants shared by the pose blend
// accumulator modules.
// ----------------------------------------------------------------------------
package spba_pkg;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [5:0]         node;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [15:0] blend_weight;
        logic               mirror;
        logic [15:0]        angle;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [19:0] out_weight;
        logic signed [15:0] out_angle;
        logic               out_identity;
        logic               skipped;
        logic               div_fault;
    } res_t;

    localparam logic [3:0] OP_TRANS    = 4'd0;
    localparam logic [3:0] OP_SCALE    = 4'd1;
    localparam logic [3:0] OP_ROTZ     = 4'd2;
    localparam logic [3:0] OP_TRANS_ID = 4'd3;
    localparam logic [3:0] OP_SCALE_ID = 4'd4;
    localparam logic [3:0] OP_CLEAR    = 4'd5;
    localparam logic [3:0] OP_KEEP     = 4'd6;
    localparam logic [3:0] OP_READ_T   = 4'd7;
    localparam logic [3:0] OP_READ_SR  = 4'd8;

    localparam logic [1:0] CFG_PELVIS = 2'd0;
    localparam logic [1:0] CFG_SPINE  = 2'd1;
    localparam logic [1:0] CFG_THRESH = 2'd2;

    localparam logic [11:0]        THRESH_RESET = 12'd4;
    localparam logic signed [31:0] ONE_Q16      = 32'sd65536;
    localparam logic signed [19:0] KEEP_WEIGHT  = 20'sd4096;
    localparam logic signed [20:0] WMAX         = 21'sd524287;
    localparam logic signed [20:0] WMIN         = -21'sd524288;
    localparam int                 T_W          = 22;
    localparam logic signed [T_W-1:0] TMAX      = 22'sd1048576;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DSTART,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       load;
        logic       sum;
        logic       div_start;
        logic       t_load;
        logic       mul;
        logic       acc;
        logic       write;
        logic       out_load;
        logic [1:0] comp;
    } cmd_t;

    typedef struct packed {
        logic lerp;
        logic single;
        logic div_done;
        logic res_free;
    } sts_t;

endpackage

/* src/spba_div.sv */
// ----------------------------------------------------------------------------
// spba_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spba_div
    import spba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [19:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [19:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [19:0] div_reg, div_next;
    logic [20:0] trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[31]};
        if (start)
        begin
            cnt_next  = 6'd0;
            busy_next = 1'b1;
            done_next = 1'b0;
            rem_next  = 20'd0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = 20'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[19:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/spba_datapath.sv */
// ----------------------------------------------------------------------------
// spba_datapath
// Node stores, configuration registers, weight/t forming, lerp multiply and
// the result register.
// ----------------------------------------------------------------------------
module spba_datapath
    import spba_pkg::*;
#(
    parameter int NODES = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  req_t       req,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [11:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output res_t       out_data
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int VW = 116;

    // Configuration.
    logic [5:0]  pelvis_reg, spine_reg;
    logic [11:0] thr_reg;

    // Node stores; valid bits stand in for the reset contents.
    logic [VW-1:0] tmem [NODES];
    logic [VW-1:0] smem [NODES];
    logic [35:0]   rmem [NODES];
    logic [VW-1:0] tmq_reg, smq_reg;
    logic [35:0]   rmq_reg;
    logic [NODES-1:0] tval_reg, sval_reg, rval_reg;
    logic [NODES-1:0] tid_reg, sid_reg, rid_reg, keep_reg;

    // Request registers.
    logic [3:0]         op_reg;
    logic [IW-1:0]      idx_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic signed [15:0] w_reg;
    logic [15:0]        ang_reg;
    logic               bad_reg, skip_reg, lerp_reg, fault_reg;

    // Working values.
    logic signed [31:0]    cx_reg, cy_reg, cz_reg;
    logic signed [19:0]    cw_reg;
    logic [15:0]           ca_reg;
    logic signed [T_W-1:0] t_reg;
    logic signed [39:0]    plo_reg;
    logic signed [37:0]    phi_reg;

    logic       res_valid_reg;
    res_t       res_reg;

    // Load decode.
    logic [IW-1:0]      idx_in;
    logic               bad_in, skip_in, lerp_in;
    logic signed [16:0] wext;
    logic [16:0]        wmag;
    logic signed [31:0] vy_in, vz_in;

    function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v == 32'sh8000_0000)
            r = 32'sh7fff_ffff;
        else
            r = -v;
        return r;
    endfunction

    always_comb
    begin
        idx_in  = IW'(req.node);
        bad_in  = (req.opcode > OP_READ_SR) || (32'(req.node) >= NODES);
        wext    = {req.blend_weight[15], req.blend_weight};
        wmag    = req.blend_weight[15] ? 17'(-wext) : 17'(wext);
        skip_in = (req.opcode <= OP_SCALE_ID) && (wmag < {5'd0, req.blend_weight[15] ?
                  thr_reg : thr_reg});
        lerp_in = 1'b0;
        case (req.opcode)
            OP_TRANS, OP_SCALE, OP_ROTZ: lerp_in = 1'b1;
            OP_TRANS_ID: lerp_in = !tid_reg[idx_in];
            OP_SCALE_ID: lerp_in = !sid_reg[idx_in];
            default:     lerp_in = 1'b0;
        endcase
        lerp_in = lerp_in && !bad_in && !skip_in;
        vy_in = req.vec_y;
        vz_in = req.vec_z;
        if (req.mirror && req.opcode == OP_TRANS)
        begin
            if (req.node <= pelvis_reg || req.node == spine_reg)
                vy_in = neg32(req.vec_y);
            else
                vz_in = neg32(req.vec_z);
        end
    end

    // Sum stage: effective stored values and new weight.
    logic [VW-1:0]      t_eff, s_eff, g_eff;
    logic [35:0]        r_eff;
    logic               is_scale;
    logic signed [19:0] w_old;
    logic signed [20:0] wsum, wsat;

    always_comb
    begin
        t_eff    = tval_reg[idx_reg] ? tmq_reg : '0;
        s_eff    = sval_reg[idx_reg] ? smq_reg : {ONE_Q16, ONE_Q16, ONE_Q16, 20'sd0};
        r_eff    = rval_reg[idx_reg] ? rmq_reg : '0;
        is_scale = (op_reg == OP_SCALE) || (op_reg == OP_SCALE_ID) || (op_reg == OP_READ_SR);
        g_eff    = is_scale ? s_eff : t_eff;
        w_old    = (op_reg == OP_ROTZ) ? $signed(r_eff[19:0]) : $signed(g_eff[19:0]);
        wsum     = 21'(w_old) + 21'(w_reg);
        if (wsum > WMAX)
            wsat = WMAX;
        else if (wsum < WMIN)
            wsat = WMIN;
        else
            wsat = wsum;
    end

    // Divider and t.
    logic [31:0]           dividend, quotient;
    logic [19:0]           divisor;
    logic                  div_done;
    logic [16:0]           wm_abs;
    logic signed [T_W-1:0] t_in, q_sat;
    logic                  zero_acc;

    always_comb
    begin
        wm_abs   = w_reg[15] ? 17'(-{w_reg[15], w_reg}) : 17'({w_reg[15], w_reg});
        dividend = {wm_abs[15:0], 16'd0};
        divisor  = cw_reg[19] ? 20'(-cw_reg) : 20'(cw_reg);
        zero_acc = (cw_reg == 20'sd0);
        if (quotient > 32'(TMAX))
            q_sat = TMAX;
        else
            q_sat = $signed(T_W'(quotient));
        if (zero_acc)
        begin
            if (w_reg > 16'sd0)
                t_in = TMAX;
            else if (w_reg < 16'sd0)
                t_in = -TMAX;
            else
                t_in = '0;
        end
        else if (w_reg[15] ^ cw_reg[19])
            t_in = -q_sat;
        else
            t_in = q_sat;
    end

    spba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Multiply: the 33-bit difference is split into two partial products.
    logic signed [31:0] cur, tgt;
    logic signed [32:0] dif;
    logic [15:0]        dang;

    always_comb
    begin
        case (cmd.comp)
            2'd0:    cur = cx_reg;
            2'd1:    cur = cy_reg;
            default: cur = cz_reg;
        endcase
        case (op_reg)
            OP_TRANS_ID: tgt = 32'sd0;
            OP_SCALE_ID: tgt = ONE_Q16;
            default:
            begin
                case (cmd.comp)
                    2'd0:    tgt = vx_reg;
                    2'd1:    tgt = vy_reg;
                    default: tgt = vz_reg;
                endcase
            end
        endcase
        dang = ang_reg - ca_reg;
        if (op_reg == OP_ROTZ)
            dif = 33'($signed(dang));
        else
            dif = 33'(tgt) - 33'(cur);
    end

    logic signed [54:0] prod, rnd, pang, lsum;
    logic signed [31:0] lres;

    always_comb
    begin
        prod = (55'(phi_reg) <<< 17) + 55'(plo_reg);
        rnd  = (prod + 55'sd32768) >>> 16;
        lsum = 55'(cur) + rnd;
        if (lsum > 55'sh7fff_ffff)
            lres = 32'sh7fff_ffff;
        else if (lsum < -55'sh8000_0000)
            lres = 32'sh8000_0000;
        else
            lres = 32'(lsum);
        if (prod < 0)
            pang = (prod + 55'sd65535) >>> 16;
        else
            pang = prod >>> 16;
    end

    // Result assembly.
    res_t res_in;
    logic id_sel;

    always_comb
    begin
        if (op_reg == OP_ROTZ)
            id_sel = rid_reg[idx_reg];
        else if (is_scale)
            id_sel = sid_reg[idx_reg];
        else
            id_sel = tid_reg[idx_reg];
        res_in = '0;
        if (!bad_reg)
        begin
            if (op_reg != OP_ROTZ)
            begin
                res_in.out_x = cx_reg;
                res_in.out_y = cy_reg;
                res_in.out_z = cz_reg;
            end
            res_in.out_weight   = cw_reg;
            res_in.out_angle    = $signed(ca_reg);
            res_in.out_identity = id_sel;
            res_in.skipped      = skip_reg;
            res_in.div_fault    = fault_reg;
        end
    end

    logic do_write;
    assign do_write = cmd.write && !bad_reg && !skip_reg;

    // Control state: configuration, marks, valid bits, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pelvis_reg    <= 6'd0;
            spine_reg     <= 6'd0;
            thr_reg       <= THRESH_RESET;
            tval_reg      <= '0;
            sval_reg      <= '0;
            rval_reg      <= '0;
            tid_reg       <= '1;
            sid_reg       <= '1;
            rid_reg       <= '1;
            keep_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PELVIS: pelvis_reg <= cfg_data[5:0];
                    CFG_SPINE:  spine_reg  <= cfg_data[5:0];
                    CFG_THRESH: thr_reg    <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.load && req.opcode == OP_CLEAR && !bad_in)
            begin
                sval_reg <= '0;
                rval_reg <= '0;
                sid_reg  <= '1;
                rid_reg  <= '1;
                tval_reg <= tval_reg & keep_reg;
                tid_reg  <= tid_reg | ~keep_reg;
            end
            if (do_write)
            begin
                case (op_reg)
                    OP_TRANS:
                    begin
                        tval_reg[idx_reg] <= 1'b1;
                        tid_reg[idx_reg]  <= 1'b0;
                    end
                    OP_TRANS_ID: tval_reg[idx_reg] <= 1'b1;
                    OP_KEEP:
                    begin
                        tval_reg[idx_reg] <= 1'b1;
                        tid_reg[idx_reg]  <= 1'b0;
                        keep_reg[idx_reg] <= 1'b1;
                    end
                    OP_SCALE:
                    begin
                        sval_reg[idx_reg] <= 1'b1;
                        sid_reg[idx_reg]  <= 1'b0;
                    end
                    OP_SCALE_ID: sval_reg[idx_reg] <= 1'b1;
                    OP_ROTZ:
                    begin
                        rval_reg[idx_reg] <= 1'b1;
                        rid_reg[idx_reg]  <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (cmd.out_load)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (do_write && (op_reg == OP_TRANS || op_reg == OP_TRANS_ID || op_reg == OP_KEEP))
            tmem[idx_reg] <= {cx_reg, cy_reg, cz_reg, cw_reg};
        if (do_write && (op_reg == OP_SCALE || op_reg == OP_SCALE_ID))
            smem[idx_reg] <= {cx_reg, cy_reg, cz_reg, cw_reg};
        if (do_write && op_reg == OP_ROTZ)
            rmem[idx_reg] <= {ca_reg, cw_reg};
        tmq_reg <= tmem[idx_reg];
        smq_reg <= smem[idx_reg];
        rmq_reg <= rmem[idx_reg];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req.opcode;
            idx_reg  <= idx_in;
            vx_reg   <= req.vec_x;
            vy_reg   <= vy_in;
            vz_reg   <= vz_in;
            w_reg    <= req.blend_weight;
            ang_reg  <= req.angle;
            bad_reg  <= bad_in;
            skip_reg <= skip_in;
            lerp_reg <= lerp_in;
        end
        if (cmd.load)
            fault_reg <= 1'b0;
        else if (cmd.t_load)
            fault_reg <= zero_acc;
        if (cmd.sum)
        begin
            cx_reg <= $signed(g_eff[115:84]);
            cy_reg <= $signed(g_eff[83:52]);
            cz_reg <= $signed(g_eff[51:20]);
            cw_reg <= w_old;
            ca_reg <= r_eff[35:20];
            if (op_reg <= OP_SCALE_ID && !skip_reg)
                cw_reg <= 20'(wsat);
            if (op_reg == OP_KEEP)
            begin
                cx_reg <= vx_reg;
                cy_reg <= vy_reg;
                cz_reg <= vz_reg;
                cw_reg <= KEEP_WEIGHT;
            end
        end
        if (cmd.t_load)
            t_reg <= t_in;
        if (cmd.mul)
        begin
            plo_reg <= 40'(t_reg * $signed({1'b0, dif[16:0]}));
            phi_reg <= 38'(t_reg * $signed(dif[32:17]));
        end
        if (cmd.acc)
        begin
            if (op_reg == OP_ROTZ)
                ca_reg <= ca_reg + pang[15:0];
            else
            begin
                case (cmd.comp)
                    2'd0:    cx_reg <= lres;
                    2'd1:    cy_reg <= lres;
                    default: cz_reg <= lres;
                endcase
            end
        end
        if (cmd.out_load)
            res_reg <= res_in;
    end

    assign sts.lerp     = lerp_reg;
    assign sts.single   = (op_reg == OP_ROTZ);
    assign sts.div_done = div_done;
    assign sts.res_free = !res_valid_reg || !out_stall;
    assign out_valid    = res_valid_reg;
    assign out_data     = res_reg;

endmodule

/* src/spba_ctrl.sv */
// ----------------------------------------------------------------------------
// spba_ctrl
// Sequencer for one request: read, weight sum, divide and per-component lerp
// (for a lerp only), write back and result hand-off.
// ----------------------------------------------------------------------------
module spba_ctrl
    import spba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [1:0] comp_reg, comp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                comp_next = 2'd0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_SUM;
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = sts.lerp ? ST_DSTART : ST_WRITE;
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.t_load = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (sts.single || comp_reg == 2'd2)
                    state_next = ST_WRITE;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.res_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* src/skeleton_pose_blend_accumulator_core.sv */
// ----------------------------------------------------------------------------
// skeleton_pose_blend_accumulator_core
// Per-node translation, scale and Z-angle blend accumulators.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  req_t
// out       output     out_valid/out_stall res_t
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A blend that forms t runs the 32-step serial divider, which sets most of
// its time, then a multiply and an accumulate step per lerped component on
// the split multiplier (one component for a Z angle). Other requests skip
// the divider and the multiplier, and the next request can be taken in the
// cycle after the result loads. Clear acts on per-node valid bits. Reset
// clears the configuration, marks and valid bits, not the node stores. A
// stalled result waits in the output register while the next request is taken.
module skeleton_pose_blend_accumulator_core
    import spba_pkg::*;
#(
    parameter int NODES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output res_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    spba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    spba_datapath #(
        .NODES (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
